/* rtl/tile_rle_decoder_top_defines.svh */
// Assertion macros used by the tile run-length decoder sequencer, trd_seq.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TILE_RLE_DECODER_TOP_DEFINES_SVH
`define TILE_RLE_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/trd_pkg.sv */
// Package for the tile run-length decoder: widths, code thresholds, FSM states
// and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package trd_pkg;

    localparam int DIM_W  = 13;
    localparam int CW     = 14;
    localparam int CNT_W  = 26;
    localparam int IDX_W  = 24;
    localparam int RPT_W  = 6;
    localparam int PEND_W = 7;
    localparam int ADDR_W = 3;

    localparam logic [7:0] SKIP_MIN     = 8'd192;
    localparam logic [7:0] LITERAL_MIN  = 8'd128;
    localparam logic [7:0] STEP_RUN_MIN = 8'd64;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_RUN,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [CNT_W-1:0] expected;
    } dims_t;

    typedef struct packed {
        logic             pre_step;
        logic             emit_en;
        logic [PEND_W-1:0] post_add;
        logic [CW-1:0]    column;
        logic [CW-1:0]    row;
        logic [CNT_W-1:0] written;
    } step_req_t;

    typedef struct packed {
        logic             emit;
        logic [CW-1:0]    column;
        logic [CW-1:0]    row;
        logic [CNT_W-1:0] written;
    } step_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [7:0]       value;
        logic [IDX_W-1:0] index;
        logic             last;
    } push_t;

endpackage

/* rtl/trd_if.sv */
// Request channel interfaces for the tile run-length decoder.
// Depends on nothing; payload widths match the decoder fields.
`timescale 1ns / 1ps

interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       tile_start;

    modport source (output valid, output data_byte, output tile_start, input ready);
    modport sink (input valid, input data_byte, input tile_start, output ready);
endinterface

interface trd_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [23:0] pixel_index;
    logic        last_of_run;

    modport source (output valid, output pixel_value, output pixel_index,
                    output last_of_run, input ready);
    modport sink (input valid, input pixel_value, input pixel_index,
                  input last_of_run, output ready);
endinterface

/* rtl/trd_cfg.sv */
// APB register file for tile width and height, with clamped dimensions and
// the registered pixel count of the tile. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_cfg
    import trd_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dims_t             dims
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [CNT_W-1:0] expected_reg;
    logic [CNT_W-1:0] expected_next;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
            expected_reg <= '0;
        end
        else
        begin
            if (wr_en && (paddr[2] == REG_WIDTH))
            begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            if (wr_en && (paddr[2] == REG_HEIGHT))
            begin
                height_reg <= pwdata[DIM_W-1:0];
            end
            expected_reg <= expected_next;
        end
    end

    always_comb
    begin
        w_eff = (32'(width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_reg;
        h_eff = (32'(height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_reg;
        expected_next = CNT_W'(w_eff) * CNT_W'(h_eff);
    end

    always_comb
    begin
        if (paddr[2] == REG_HEIGHT)
        begin
            prdata = 32'(height_reg);
        end
        else
        begin
            prdata = 32'(width_reg);
        end
    end

    assign dims.w        = w_eff;
    assign dims.h        = h_eff;
    assign dims.expected = expected_reg;

endmodule

/* rtl/trd_step.sv */
// Shared column and row step unit: optional pre-step, clip test for one copy,
// then a column advance with a single wrap to the next row. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_step
    import trd_pkg::*;
(
    input  step_req_t req,
    input  dims_t     dims,
    output step_rsp_t rsp
);

    logic [CW-1:0] col_a;
    logic [CW-1:0] col_b;
    logic [CW-1:0] w_ext;
    logic [CW-1:0] h_ext;

    always_comb
    begin
        w_ext = CW'(dims.w);
        h_ext = CW'(dims.h);
        col_a = req.column + CW'(req.pre_step);
        rsp.emit = req.emit_en && (col_a < w_ext) && (req.row < h_ext)
                   && (req.written < dims.expected);
        rsp.written = req.written + CNT_W'(rsp.emit);
        col_b = col_a + CW'(req.post_add);
        if (col_b >= w_ext)
        begin
            rsp.column = '0;
            rsp.row    = req.row + CW'(1);
        end
        else
        begin
            rsp.column = col_b;
            rsp.row    = req.row;
        end
    end

endmodule

/* rtl/trd_seq.sv */
// Decode sequencer: holds decode state, classifies control bytes, runs one copy
// per cycle through trd_step unless stalled. Depends on trd_pkg and defines.
`timescale 1ns / 1ps
`include "tile_rle_decoder_top_defines.svh"

module trd_seq
    import trd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       tile_start,
    input  dims_t      dims,
    input  logic       out_free,
    output push_t      push
);

    state_t            state_reg, state_next;
    logic [7:0]        b_reg, b_next;
    logic [CW-1:0]     column_reg, column_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CNT_W-1:0]  written_reg, written_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [RPT_W-1:0]  repeat_reg, repeat_next;
    logic [7:0]        control_reg, control_next;
    logic              finished_reg, finished_next;
    logic [RPT_W-1:0]  iter_reg, iter_next;
    logic              held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]  held_index_reg, held_index_next;

    step_req_t step_req;
    step_rsp_t step_rsp;
    logic      done_cond;
    logic      end_cond;
    logic      stepped;
    logic      clear_now;

    trd_step u_step (
        .req  (step_req),
        .dims (dims),
        .rsp  (step_rsp)
    );

    assign end_cond  = (row_reg >= CW'(dims.h)) || (written_reg >= dims.expected);
    assign done_cond = finished_reg || end_cond;
    assign stepped   = (control_reg >= STEP_RUN_MIN) && (control_reg < LITERAL_MIN);
    assign clear_now = (state_reg == S_IDLE) && in_valid && tile_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            column_reg     <= '0;
            row_reg        <= '0;
            written_reg    <= '0;
            pending_reg    <= '0;
            repeat_reg     <= '0;
            control_reg    <= '0;
            finished_reg   <= 1'b0;
            iter_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            written_reg    <= written_next;
            pending_reg    <= pending_next;
            repeat_reg     <= repeat_next;
            control_reg    <= control_next;
            finished_reg   <= finished_next;
            iter_reg       <= iter_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg          <= b_next;
        held_index_reg <= held_index_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        b_next          = b_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        written_next    = written_reg;
        pending_next    = pending_reg;
        repeat_next     = repeat_reg;
        control_next    = control_reg;
        finished_next   = finished_reg;
        iter_next       = iter_reg;
        held_valid_next = held_valid_reg;
        held_index_next = held_index_reg;
        in_ready        = 1'b0;

        step_req.pre_step = 1'b0;
        step_req.emit_en  = 1'b0;
        step_req.post_add = '0;
        step_req.column   = column_reg;
        step_req.row      = row_reg;
        step_req.written  = written_reg;

        push.valid = 1'b0;
        push.value = b_reg;
        push.index = held_index_reg;
        push.last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    b_next = data_byte;
                    if (tile_start)
                    begin
                        column_next   = '0;
                        row_next      = '0;
                        written_next  = '0;
                        pending_next  = '0;
                        repeat_next   = '0;
                        control_next  = '0;
                        finished_next = 1'b0;
                    end
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (done_cond)
                begin
                    finished_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (pending_reg == '0)
                begin
                    control_next = b_reg;
                    repeat_next  = '0;
                    if (b_reg >= SKIP_MIN)
                    begin
                        step_req.post_add = PEND_W'(b_reg[5:0]) + PEND_W'(1);
                    end
                    else if (b_reg >= LITERAL_MIN)
                    begin
                        pending_next = PEND_W'(b_reg[5:0]) + PEND_W'(1);
                    end
                    else
                    begin
                        repeat_next  = b_reg[RPT_W-1:0];
                        pending_next = PEND_W'(1);
                    end
                    column_next = step_rsp.column;
                    row_next    = step_rsp.row;
                    state_next  = S_FINAL;
                end
                else
                begin
                    pending_next = pending_reg - PEND_W'(1);
                    iter_next    = '0;
                    state_next   = S_RUN;
                end
            end
            S_RUN:
            begin
                step_req.pre_step = stepped;
                step_req.emit_en  = 1'b1;
                step_req.post_add = PEND_W'(1);
                if (!(step_rsp.emit && held_valid_reg && !out_free))
                begin
                    column_next  = step_rsp.column;
                    row_next     = step_rsp.row;
                    written_next = step_rsp.written;
                    if (step_rsp.emit)
                    begin
                        push.valid      = held_valid_reg;
                        held_valid_next = 1'b1;
                        held_index_next = written_reg[IDX_W-1:0];
                    end
                    if (iter_reg == repeat_reg)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        iter_next = iter_reg + RPT_W'(1);
                    end
                end
            end
            S_FINAL:
            begin
                push.last = 1'b1;
                if (!held_valid_reg || out_free)
                begin
                    push.valid      = held_valid_reg;
                    held_valid_next = 1'b0;
                    finished_next   = finished_reg || end_cond;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TRD_ASSERT_SAME(a_push_has_room, push.valid, out_free,
        "pixel pushed while the output register is occupied")
    `TRD_ASSERT_SAME(a_idle_no_held, state_reg == S_IDLE, !held_valid_reg,
        "held pixel left behind after the byte finished")
    `TRD_ASSERT_SAME(a_iter_bound, state_reg == S_RUN, iter_reg <= repeat_reg,
        "copy counter ran past the repeat count")
    `TRD_ASSERT_NEXT(a_finished_sticky, finished_reg && !clear_now, finished_reg,
        "finished flag dropped without a tile start")

endmodule

/* rtl/tile_rle_decoder_top.sv */
// Tile run-length decoder top level: APB configuration, decode sequencer and
// the output register. Depends on trd_pkg, trd_if, trd_cfg and trd_seq.
//
// Compressed bytes arrive on byte_ch; tile_start on a byte clears the column,
// row, pixel count and code state before that byte is used. Decoded pixels
// leave on pixel_ch with their packed index and a last_of_run mark on the
// final pixel a byte produced. Tile width and height are written over APB
// (width at address 0, height at address 4); the user must write them only
// while the decoder is idle, which the block itself does not enforce.
// The decoder works on one byte at a time. A control byte passes through the
// decode and final states, then idle takes the next byte. A data byte also
// runs the copy state once per copy, N copies in all (1 for a literal, up to
// 64 for a run), as the single shared column step unit handles one copy per
// cycle while the receiver does not stall. A byte that arrives after the tile
// is finished goes from the decode state straight back to idle. A pixel goes
// from the copy state into the held slot and then the output register. One
// pixel is held back so that the last one can be marked; when the receiver
// stalls, the copy loop waits until the output register frees.
// Reset restores 16 by 16 dimensions and an empty, unfinished decode state.
`timescale 1ns / 1ps

module tile_rle_decoder_top
    import trd_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    trd_byte_if.sink          byte_ch,
    trd_pixel_if.source       pixel_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    dims_t            dims;
    push_t            push;
    logic             out_free;
    logic             out_valid_reg;
    logic [7:0]       out_value_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_last_reg;

    trd_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    trd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_ch.valid),
        .in_ready   (byte_ch.ready),
        .data_byte  (byte_ch.data_byte),
        .tile_start (byte_ch.tile_start),
        .dims       (dims),
        .out_free   (out_free),
        .push       (push)
    );

    assign out_free = !out_valid_reg || pixel_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_value_reg <= push.value;
            out_index_reg <= push.index;
            out_last_reg  <= push.last;
        end
    end

    assign pixel_ch.valid       = out_valid_reg;
    assign pixel_ch.pixel_value = out_value_reg;
    assign pixel_ch.pixel_index = out_index_reg;
    assign pixel_ch.last_of_run = out_last_reg;

endmodule
